>>> hdl/sps_pkg.sv
`default_nettype none

package sps_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	// one item's partial sum: at most MAX_ITEMS values of 32 bits
	localparam int PART_W    = 32 + $clog2(MAX_ITEMS);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_item;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] total;
		logic               overflow;
	} out_word_t;

	// word moving down the cell chain
	typedef struct packed {
		logic                     valid;
		logic                     live;     // compares against stored values
		logic                     placed;   // already stored in a cell or dropped
		logic                     last;
		logic                     overflow;
		logic signed [31:0]       value;
		logic signed [PART_W-1:0] partial;
	} tok_t;

endpackage

`default_nettype wire

>>> hdl/smaller_predecessor_sum_core.sv
// Path: an accepted word is registered in the first cell at the edge that accepts it,
// then in each further cell in turn; a last word's total then goes into the result
// register. Any halt of the chain delays it.
// Throughput: one word per cycle; the whole chain halts while a result waits.
// Reset: asynchronous, active low; clears cell occupancy, word valids, counters,
// the accumulator and the result valid flag. Stored values need no clearing.
`default_nettype none

module smaller_predecessor_sum_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire sps_pkg::in_word_t item,
	output logic                result_valid,
	input  wire logic           result_ready,
	output sps_pkg::out_word_t  result
);

	logic                        en;
	logic                        accept;
	logic [sps_pkg::CNT_W-1:0]   count_q;
	logic                        ovf_q;
	logic                        room;
	logic signed [63:0]          acc_q;
	logic signed [63:0]          acc_sum;
	logic                        res_valid_q;
	sps_pkg::out_word_t          res_q;
	sps_pkg::tok_t               tok [sps_pkg::MAX_ITEMS+1];
	sps_pkg::tok_t               tail;

	assign en         = !res_valid_q || result_ready;
	assign item_ready = en;
	assign accept     = item_valid && en;
	assign room       = count_q < sps_pkg::CNT_W'(sps_pkg::MAX_ITEMS);

	always_comb begin
		tok[0].valid    = accept;
		tok[0].live     = room;
		tok[0].placed   = !room;
		tok[0].last     = item.last_item;
		tok[0].overflow = ovf_q || !room;
		tok[0].value    = item.value;
		tok[0].partial  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (item.last_item) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (room) begin
				count_q <= count_q + sps_pkg::CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	for (genvar g = 0; g < sps_pkg::MAX_ITEMS; g++) begin : g_cell
		sps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	assign tail    = tok[sps_pkg::MAX_ITEMS];
	assign acc_sum = acc_q + {{(64-sps_pkg::PART_W){tail.partial[sps_pkg::PART_W-1]}},
		tail.partial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= tail.valid && tail.last;
			if (tail.valid) begin
				acc_q <= tail.last ? 64'sd0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tail.valid && tail.last) begin
			res_q.total    <= acc_sum;
			res_q.overflow <= tail.overflow;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sps_pkg::CNT_W'(sps_pkg::MAX_ITEMS))
		else $error("entry count beyond capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.last_item |=> count_q == '0 && !ovf_q)
		else $error("set state not cleared after last word");

	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !room && !item.last_item |=> ovf_q)
		else $error("dropped word did not raise overflow");

	a_tail_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && tail.valid && tail.last |=> result_valid)
		else $error("last word left chain without result");

	a_no_stall_move: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(acc_q) && $stable(count_q))
		else $error("state changed during stall");

endmodule

`default_nettype wire

>>> hdl/sps_cell.sv
`default_nettype none

module sps_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire sps_pkg::tok_t tok_in,
	output sps_pkg::tok_t     tok_out
);

	logic                             occupied_q;
	logic signed [31:0]               stored_q;
	sps_pkg::tok_t                    tok_q;
	sps_pkg::tok_t                    tok_d;
	logic                             hit;
	logic                             take;
	logic signed [sps_pkg::PART_W-1:0] stored_ext;

	assign stored_ext = {{(sps_pkg::PART_W-32){stored_q[31]}}, stored_q};
	assign hit        = tok_in.valid && tok_in.live && occupied_q && (stored_q < tok_in.value);
	assign take       = tok_in.valid && !tok_in.placed && !occupied_q;

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.partial = tok_in.partial + stored_ext;
		end
		if (take) begin
			tok_d.placed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
			tok_q      <= '0;
		end else if (en) begin
			tok_q <= tok_d;
			if (tok_in.valid) begin
				occupied_q <= tok_in.last ? 1'b0 : (occupied_q | take);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				stored_q <= tok_in.value;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

>>> dv/inversion_sum_checker.sv
`timescale 1ns / 100ps

module inversion_sum_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	input  wire logic          item_ready,
	input  sps_pkg::in_word_t  item,
	input  wire logic          result_valid,
	input  wire logic          result_ready,
	input  sps_pkg::out_word_t result,
	output int                 mismatches,
	output int                 pending
);

	logic signed [31:0] set_vals [sps_pkg::MAX_ITEMS];
	int                 set_len;
	logic        [63:0] set_sum;
	logic               set_dropped;
	sps_pkg::out_word_t totals_due [$];
	sps_pkg::out_word_t want;

	initial begin
		mismatches  = 0;
		pending     = 0;
		set_len     = 0;
		set_sum     = '0;
		set_dropped = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t mismatch on %s: got %h, want %h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// accumulate the sum of earlier strictly smaller values of the set
	task automatic absorb_word(input sps_pkg::in_word_t w);
		logic signed [31:0] v;
		logic        [63:0] add;
		sps_pkg::out_word_t done;
		v   = w.value;
		add = '0;
		if (set_len < sps_pkg::MAX_ITEMS) begin
			for (int k = 0; k < set_len; k++)
				if (set_vals[k] < v)
					add += {{32{set_vals[k][31]}}, set_vals[k]};
			set_sum          += add;
			set_vals[set_len] = v;
			set_len++;
		end else begin
			set_dropped = 1'b1;
		end
		if (w.last_item) begin
			done.total    = set_sum;
			done.overflow = set_dropped;
			totals_due.push_back(done);
			set_len     = 0;
			set_sum     = '0;
			set_dropped = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (totals_due.size() == 0) begin
					report_mismatch("unexpected word", result.total, '0);
				end else begin
					want = totals_due.pop_front();
					if (result.total !== want.total)
						report_mismatch("total", result.total, want.total);
					if (result.overflow !== want.overflow)
						report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
				end
			end
			if (item_valid && item_ready)
				absorb_word(item);
			pending = totals_due.size();
		end
	end

endmodule

>>> dv/smaller_predecessor_sum_core_tb.sv
`timescale 1ns / 100ps

module smaller_predecessor_sum_core_tb;

	typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} val_mode_t;

	localparam logic signed [31:0] V_MIN     = 32'sh8000_0000;
	localparam logic signed [31:0] V_MAX     = 32'sh7FFF_FFFF;
	localparam int                 HOLD_LEN  = 3000;
	localparam int                 RAND_WORDS = 1850;
	localparam int                 CALM_TAIL = 200;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	sps_pkg::in_word_t  item         = '0;
	logic               result_ready = 1'b0;
	logic               idle_on      = 1'b1;
	logic               hold_go      = 1'b0;
	logic               item_ready;
	logic               result_valid;
	sps_pkg::out_word_t result;
	int                 mismatches;
	int                 pending;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	smaller_predecessor_sum_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	inversion_sum_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic signed [31:0] pick_value(input val_mode_t mode);
		case (mode)
			VAL_NARROW: return $signed($urandom_range(0, 8)) - 4;
			VAL_EDGE: begin
				case ($urandom_range(0, 5))
					0: return V_MIN;
					1: return V_MAX;
					2: return 0;
					3: return -1;
					4: return V_MIN + 1;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic signed [31:0] v, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{value: v, last_item: last};
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic send_set(input int len, input val_mode_t mode);
		for (int i = 0; i < len; i++)
			send_word(pick_value(mode), i == len - 1);
	endtask

	// receiver: short random stalls, one long hold-off on request
	initial begin : sink
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !held) begin
				held          = 1'b1;
				result_ready <= 1'b0;
				for (n = 0; n < HOLD_LEN; n++)
					@(negedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				n = $urandom_range(1, 3);
				repeat (n - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int sent;
		int len;
		@(posedge arst_n);
		@(negedge clk);

		send_word(V_MIN, 1'b1);
		send_word(V_MAX, 1'b1);

		send_word(V_MIN, 1'b0);
		send_word(V_MAX, 1'b0);
		send_word(0, 1'b0);
		send_word(-1, 1'b0);
		send_word(V_MAX, 1'b0);
		send_word(V_MIN, 1'b0);
		send_word(1, 1'b1);

		// equal values add nothing
		send_word(7, 1'b0);
		send_word(7, 1'b0);
		send_word(7, 1'b0);
		send_word(7, 1'b1);

		send_word(5, 1'b0);
		send_word(4, 1'b0);
		send_word(3, 1'b0);
		send_word(-2, 1'b0);
		send_word(V_MIN, 1'b1);

		send_word(V_MIN, 1'b0);
		send_word(V_MIN + 1, 1'b0);
		send_word(-1, 1'b0);
		send_word(V_MAX, 1'b1);

		hold_go <= 1'b1;
		sent = 0;
		while (sent < 400) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			send_set(len, val_mode_t'($urandom_range(0, 2)));
			sent += len;
		end

		// overfull set: the tail, last word included, is dropped
		len = sps_pkg::MAX_ITEMS + $urandom_range(1, 3);
		send_set(len, val_mode_t'($urandom_range(0, 2)));
		sent += len;

		while (sent < RAND_WORDS) begin
			if (sent >= RAND_WORDS - CALM_TAIL)
				idle_on <= 1'b0;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			send_set(len, val_mode_t'($urandom_range(0, 2)));
			sent += len;
		end
		item_valid <= 1'b0;

		wait (pending == 0);
		repeat (sps_pkg::MAX_ITEMS + 16) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
